// ===== hdl/assert_macros.svh =====
// assertion macros used by the deposit core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge outside reset
`define CIC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cic assertion failed");

// condition that must never be seen outside reset
`define CIC_ASSERT_NEVER(label, cond) \
  `CIC_ASSERT(label, !(cond))

`endif

// ===== hdl/cic_pkg.sv =====
// package: widths, register codes and shared types of the cloud-in-cell deposit core
package cic_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned WEIGHT_W   = 24;
  localparam int unsigned BIN_W      = 18;
  localparam int unsigned CORNER_W   = 3;
  localparam int unsigned DIMS_W     = 2;
  localparam int unsigned PTS_REG_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned NUM_AXES   = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMENSIONS   = 2'd0,
    CFG_POINTS_AXIS0 = 2'd1,
    CFG_POINTS_AXIS1 = 2'd2,
    CFG_POINTS_AXIS2 = 2'd3
  } cfg_reg_e;

  // dimensionality codes
  localparam logic [DIMS_W-1:0] DIMS_NONE = 2'd0;
  localparam logic [DIMS_W-1:0] DIMS_1D   = 2'd1;
  localparam logic [DIMS_W-1:0] DIMS_2D   = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_3D   = 2'd3;

  localparam logic [PTS_REG_W-1:0] PTS_RESET = 7'd16;

  // control that travels alongside each corner
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [CORNER_W-1:0] corner;
  } cic_tag_t;

endpackage

// ===== hdl/cic_axis_prep.sv =====
// per-axis scaling: lower cell, wrapped upper cell and fraction above the lower cell
module cic_axis_prep #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PTS_W     = 7,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [cic_pkg::POS_W-1:0]  pos_i,
  input  logic [PTS_W-1:0]           pts_i,
  output logic [IDX_W-1:0]           lo_o,
  output logic [IDX_W-1:0]           hi_o,
  output logic [FRAC_BITS-1:0]       fb_o
);

  localparam int unsigned SW = FRAC_BITS + PTS_W;

  logic [FRAC_BITS-1:0] pos_al;
  logic [SW-1:0]        scaled;
  logic [PTS_W-1:0]     lo_full;
  logic [PTS_W-1:0]     lo_inc;
  logic [IDX_W-1:0]     lo_q, hi_q;
  logic [FRAC_BITS-1:0] fb_q;

  // realign the 0.16 position to the internal fraction width
  if (FRAC_BITS >= cic_pkg::POS_W) begin : g_widen
    assign pos_al = FRAC_BITS'(pos_i) << (FRAC_BITS - cic_pkg::POS_W);
  end else begin : g_narrow
    assign pos_al = pos_i[cic_pkg::POS_W-1 -: FRAC_BITS];
  end

  assign scaled  = SW'(pos_al) * SW'(pts_i);
  assign lo_full = scaled[SW-1:FRAC_BITS];
  assign lo_inc  = lo_full + PTS_W'(1);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_q <= lo_full[IDX_W-1:0];
      hi_q <= (lo_inc < pts_i) ? lo_inc[IDX_W-1:0] : '0;
      fb_q <= scaled[FRAC_BITS-1:0];
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;
  assign fb_o = fb_q;

endmodule

// ===== hdl/cic_corner_seq.sv =====
// corner sequencer: walks the 2, 4 or 8 corners of one item, one per cycle
module cic_corner_seq #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PTS_W     = 7,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  input  logic [cic_pkg::DIMS_W-1:0]                 dims_i,
  input  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]    lo_i,
  input  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]    hi_i,
  input  logic [cic_pkg::NUM_AXES-1:0][FRAC_BITS-1:0] fb_i,
  input  logic signed [cic_pkg::WEIGHT_W-1:0]        weight_i,
  input  logic [PTS_W-1:0]                           pts1_i,
  input  logic [PTS_W-1:0]                           pts2_i,
  output logic                                       free_o,
  output cic_pkg::cic_tag_t                          tag_o,
  output logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]    idx_o,
  output logic [PTS_W-1:0]                           pts1_o,
  output logic [PTS_W-1:0]                           pts2_o,
  output logic [cic_pkg::NUM_AXES-1:0][FRAC_BITS:0]  frac_o,
  output logic signed [cic_pkg::WEIGHT_W-1:0]        weight_o
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                                        valid_q;
  logic [cic_pkg::CORNER_W-1:0]                n_q;
  logic [cic_pkg::DIMS_W-1:0]                  dims_q;
  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]     lo_q, hi_q;
  logic [cic_pkg::NUM_AXES-1:0][FRAC_BITS-1:0] fb_q;
  logic signed [cic_pkg::WEIGHT_W-1:0]         weight_q;

  logic                                        last;
  logic [cic_pkg::CORNER_W-1:0]                c;
  logic [cic_pkg::NUM_AXES-1:0]                up;
  logic [cic_pkg::NUM_AXES-1:0]                axis_on;

  // axis 0 is the most significant corner bit; 1d runs upper cell first
  always_comb begin
    unique case (dims_q)
      cic_pkg::DIMS_1D: begin
        last    = (n_q == 3'd1);
        c       = {2'b00, ~n_q[0]};
        up      = {2'b00, c[0]};
        axis_on = 3'b001;
      end
      cic_pkg::DIMS_2D: begin
        last    = (n_q == 3'd3);
        c       = n_q;
        up      = {1'b0, c[0], c[1]};
        axis_on = 3'b011;
      end
      default: begin
        last    = (n_q == 3'd7);
        c       = n_q;
        up      = {c[0], c[1], c[2]};
        axis_on = 3'b111;
      end
    endcase
  end

  assign free_o = !valid_q || last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      n_q     <= '0;
      dims_q  <= cic_pkg::DIMS_3D;
    end else if (free_o) begin
      valid_q <= in_valid_i;
      n_q     <= '0;
      if (in_valid_i) begin
        dims_q <= dims_i;
      end
    end else begin
      n_q <= n_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && in_valid_i) begin
      lo_q     <= lo_i;
      hi_q     <= hi_i;
      fb_q     <= fb_i;
      weight_q <= weight_i;
    end
  end

  // unused axes take cell 0, one point and a fraction of exactly 1.0
  always_comb begin
    for (int a = 0; a < cic_pkg::NUM_AXES; a++) begin
      if (!axis_on[a]) begin
        idx_o[a]  = '0;
        frac_o[a] = ONE;
      end else if (up[a]) begin
        idx_o[a]  = hi_q[a];
        frac_o[a] = {1'b0, fb_q[a]};
      end else begin
        idx_o[a]  = lo_q[a];
        frac_o[a] = ONE - {1'b0, fb_q[a]};
      end
    end
  end

  assign pts1_o   = axis_on[1] ? pts1_i : PTS_W'(1);
  assign pts2_o   = axis_on[2] ? pts2_i : PTS_W'(1);
  assign weight_o = weight_q;

  assign tag_o.valid  = valid_q;
  assign tag_o.last   = last;
  assign tag_o.corner = c;

endmodule

// ===== hdl/cic_share_pipe.sv =====
// three-stage share and bin index pipeline, one axis product per stage
module cic_share_pipe #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PTS_W     = 7,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  cic_pkg::cic_tag_t                         tag_i,
  input  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]   idx_i,
  input  logic [PTS_W-1:0]                          pts1_i,
  input  logic [PTS_W-1:0]                          pts2_i,
  input  logic [cic_pkg::NUM_AXES-1:0][FRAC_BITS:0] frac_i,
  input  logic signed [cic_pkg::WEIGHT_W-1:0]       weight_i,
  output cic_pkg::cic_tag_t                         tag_o,
  output logic [cic_pkg::BIN_W-1:0]                 bin_index_o,
  output logic signed [cic_pkg::WEIGHT_W-1:0]       weight_share_o
);

  localparam int unsigned WW     = cic_pkg::WEIGHT_W;
  localparam int unsigned PROD_W = WW + FRAC_BITS + 2;
  localparam int unsigned XW     = (3 * PTS_W > cic_pkg::BIN_W) ? 3 * PTS_W : cic_pkg::BIN_W;

  // product with a fraction, dropped bits rounded toward minus infinity
  function automatic logic signed [WW-1:0] scale_share(input logic signed [WW-1:0] s,
                                                       input logic [FRAC_BITS:0] f);
    logic signed [PROD_W-1:0] prod;
    prod = $signed(s) * $signed({1'b0, f});
    prod = prod >>> FRAC_BITS;
    return prod[WW-1:0];
  endfunction

  cic_pkg::cic_tag_t        t1_q, t2_q, t3_q;
  logic signed [WW-1:0]     sh1_q, sh2_q, sh3_q;
  logic [XW-1:0]            x1_q, x2_q;
  logic [cic_pkg::BIN_W-1:0] x3_q;
  logic [IDX_W-1:0]         i2_1_q;
  logic [PTS_W-1:0]         p2_1_q;
  logic [FRAC_BITS:0]       f1_1_q, f2_1_q, f2_2_q;
  logic [XW-1:0]            x2_full;

  assign x2_full = x1_q * XW'(p2_1_q) + XW'(i2_1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: axis 0 share, row index of axes 0 and 1
    sh1_q  <= scale_share(weight_i, frac_i[0]);
    x1_q   <= XW'(idx_i[0]) * XW'(pts1_i) + XW'(idx_i[1]);
    i2_1_q <= idx_i[2];
    p2_1_q <= pts2_i;
    f1_1_q <= frac_i[1];
    f2_1_q <= frac_i[2];
    // stage 2: axis 1 share, fold in axis 2
    sh2_q  <= scale_share(sh1_q, f1_1_q);
    x2_q   <= x2_full;
    f2_2_q <= f2_1_q;
    // stage 3: axis 2 share, index masked to the port
    sh3_q  <= scale_share(sh2_q, f2_2_q);
    x3_q   <= x2_q[cic_pkg::BIN_W-1:0];
  end

  assign tag_o          = t3_q;
  assign bin_index_o    = x3_q;
  assign weight_share_o = sh3_q;

endmodule

// ===== hdl/cloud_in_cell_deposit_core.sv =====
// cloud-in-cell deposit core: spreads one signed weight over 2, 4 or 8 grid cells
// path: an idle core's first corner passes prep, sequencer and share pipe registers
// throughput: the result port carries one corner per cycle; corners of an item leave
//   back to back, and the next item waits in the prep stage while they are walked
// reset: dimensions 3, 16 points per axis, all in-flight items dropped
// the receiver cannot stall, so the corner pipeline never holds
`include "assert_macros.svh"

module cloud_in_cell_deposit_core #(
  parameter int unsigned MAX_POINTS    = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [cic_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cic_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // item command
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cic_pkg::POS_W-1:0]            position_axis0_i,
  input  logic [cic_pkg::POS_W-1:0]            position_axis1_i,
  input  logic [cic_pkg::POS_W-1:0]            position_axis2_i,
  input  logic signed [cic_pkg::WEIGHT_W-1:0]  sample_weight_i,
  // corner results
  output logic                                 result_valid_o,
  output logic [cic_pkg::BIN_W-1:0]            bin_index_o,
  output logic signed [cic_pkg::WEIGHT_W-1:0]  weight_share_o,
  output logic [cic_pkg::CORNER_W-1:0]         corner_o,
  output logic                                 last_corner_o
);

  localparam int unsigned PTS_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (PTS_W > cic_pkg::PTS_REG_W) ? PTS_W : cic_pkg::PTS_REG_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_POINTS);

  // zero points reads as one, anything above the maximum saturates
  function automatic logic [PTS_W-1:0] clamp_points(input logic [cic_pkg::PTS_REG_W-1:0] p);
    logic [CMP_W-1:0] p_ext;
    p_ext = CMP_W'(p);
    if (p_ext == '0) begin
      p_ext = CMP_W'(1);
    end else if (p_ext > MAX_EXT) begin
      p_ext = MAX_EXT;
    end
    return p_ext[PTS_W-1:0];
  endfunction

  // configuration registers
  logic [cic_pkg::DIMS_W-1:0]    dims_q;
  logic [cic_pkg::PTS_REG_W-1:0] pts0_q, pts1_q, pts2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= cic_pkg::DIMS_3D;
      pts0_q <= cic_pkg::PTS_RESET;
      pts1_q <= cic_pkg::PTS_RESET;
      pts2_q <= cic_pkg::PTS_RESET;
    end else if (cfg_we_i) begin
      unique case (cic_pkg::cfg_reg_e'(cfg_index_i))
        cic_pkg::CFG_DIMENSIONS:   dims_q <= cfg_wdata_i[cic_pkg::DIMS_W-1:0];
        cic_pkg::CFG_POINTS_AXIS0: pts0_q <= cfg_wdata_i;
        cic_pkg::CFG_POINTS_AXIS1: pts1_q <= cfg_wdata_i;
        cic_pkg::CFG_POINTS_AXIS2: pts2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [cic_pkg::DIMS_W-1:0]                   dims_eff;
  logic [cic_pkg::NUM_AXES-1:0][PTS_W-1:0]      pts_eff;
  logic [cic_pkg::NUM_AXES-1:0][cic_pkg::POS_W-1:0] pos_in;

  assign dims_eff   = (dims_q == cic_pkg::DIMS_NONE) ? cic_pkg::DIMS_1D : dims_q;
  assign pts_eff[0] = clamp_points(pts0_q);
  assign pts_eff[1] = clamp_points(pts1_q);
  assign pts_eff[2] = clamp_points(pts2_q);
  assign pos_in[0]  = position_axis0_i;
  assign pos_in[1]  = position_axis1_i;
  assign pos_in[2]  = position_axis2_i;

  // prep stage: holds one scaled item until the sequencer takes it
  logic                                         accept;
  logic                                         seq_free;
  logic                                         p_valid_q, p_valid_d;
  logic signed [cic_pkg::WEIGHT_W-1:0]          p_weight_q;
  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]      p_lo, p_hi;
  logic [cic_pkg::NUM_AXES-1:0][FRACTION_BITS-1:0] p_fb;

  // busy only while a prepared item waits behind a sequencer mid-item
  assign busy   = p_valid_q && !seq_free;
  assign accept = start && !busy;

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (seq_free) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_weight_q <= sample_weight_i;
    end
  end

  for (genvar a = 0; a < cic_pkg::NUM_AXES; a++) begin : g_axis
    cic_axis_prep #(
      .FRAC_BITS (FRACTION_BITS),
      .PTS_W     (PTS_W),
      .IDX_W     (IDX_W)
    ) u_prep (
      .clk_i  (clk_i),
      .load_i (accept),
      .pos_i  (pos_in[a]),
      .pts_i  (pts_eff[a]),
      .lo_o   (p_lo[a]),
      .hi_o   (p_hi[a]),
      .fb_o   (p_fb[a])
    );
  end

  // corner sequencer
  cic_pkg::cic_tag_t                            seq_tag;
  logic [cic_pkg::NUM_AXES-1:0][IDX_W-1:0]      seq_idx;
  logic [PTS_W-1:0]                             seq_pts1, seq_pts2;
  logic [cic_pkg::NUM_AXES-1:0][FRACTION_BITS:0] seq_frac;
  logic signed [cic_pkg::WEIGHT_W-1:0]          seq_weight;

  cic_corner_seq #(
    .FRAC_BITS (FRACTION_BITS),
    .PTS_W     (PTS_W),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (p_valid_q),
    .dims_i     (dims_eff),
    .lo_i       (p_lo),
    .hi_i       (p_hi),
    .fb_i       (p_fb),
    .weight_i   (p_weight_q),
    .pts1_i     (pts_eff[1]),
    .pts2_i     (pts_eff[2]),
    .free_o     (seq_free),
    .tag_o      (seq_tag),
    .idx_o      (seq_idx),
    .pts1_o     (seq_pts1),
    .pts2_o     (seq_pts2),
    .frac_o     (seq_frac),
    .weight_o   (seq_weight)
  );

  // share and index pipeline feeding the result ports
  cic_pkg::cic_tag_t out_tag;

  cic_share_pipe #(
    .FRAC_BITS (FRACTION_BITS),
    .PTS_W     (PTS_W),
    .IDX_W     (IDX_W)
  ) u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (seq_tag),
    .idx_i          (seq_idx),
    .pts1_i         (seq_pts1),
    .pts2_i         (seq_pts2),
    .frac_i         (seq_frac),
    .weight_i       (seq_weight),
    .tag_o          (out_tag),
    .bin_index_o    (bin_index_o),
    .weight_share_o (weight_share_o)
  );

  assign result_valid_o = out_tag.valid;
  assign corner_o       = out_tag.corner;
  assign last_corner_o  = out_tag.last;

  logic one_axis;
  assign one_axis = (dims_eff == cic_pkg::DIMS_1D);

  // corners of one item leave without gaps
  `CIC_ASSERT(a_corners_contiguous, result_valid_o && !last_corner_o |=> result_valid_o)
  // a prepared item always moves into the sequencer once busy drops
  `CIC_ASSERT(a_prep_drains, p_valid_q && !busy |=> seq_tag.valid)
  // a one-axis item only uses corners 0 and 1
  `CIC_ASSERT_NEVER(a_1d_corner_range, result_valid_o && one_axis && (corner_o[2:1] != 2'b00))

endmodule
